@@ src/sky_grad_pkg.sv @@
// Shared types, constants and arithmetic helpers for the sky gradient color block.
package sky_grad_pkg;

    localparam int Q_FRAC   = 12;
    localparam int CH_W     = 13;                // Q12 channel / weight base width
    localparam int COLOR_W  = 3 * CH_W;          // packed color register
    localparam int WEIGHT_W = 17;                // up to 31.0 in Q12
    localparam int PROD_W   = WEIGHT_W + 1;      // rounded channel * weight
    localparam int SQ_W     = 27;                // square root working width
    localparam int SQ_STEPS = 14;                // bit goes 2^26 .. 2^0 by fours

    localparam logic [CH_W-1:0]     ONE_Q12     = 13'd4096;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 17'd126976;   // 31.0

    localparam logic [COLOR_W-1:0] HORIZON_RESET = 39'd200672953836;
    localparam logic [COLOR_W-1:0] ZENITH_RESET  = 39'd274910121533;
    localparam logic [COLOR_W-1:0] GROUND_RESET  = 39'd244641672765;

    localparam logic [1:0] CFG_HORIZON = 2'd0;
    localparam logic [1:0] CFG_ZENITH  = 2'd1;
    localparam logic [1:0] CFG_GROUND  = 2'd2;

    typedef logic [CH_W-1:0]     t_q12;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [PROD_W-1:0]   t_prod;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } t_sqrt;

    // Rounded Q12 multiply, operands and result within 0 .. 1.0
    function automatic t_q12 qmul(input t_q12 x, input t_q12 y);
        logic [2*CH_W-1:0] prod;
        logic [2*CH_W:0]   sum;
        prod = x * y;
        sum  = {1'b0, prod} + (27'd1 << (Q_FRAC - 1));
        return sum[Q_FRAC +: CH_W];
    endfunction

    // Rounded Q12 multiply of a color channel by a weight
    function automatic t_prod cmul(input t_q12 c, input t_weight p);
        logic [CH_W+WEIGHT_W-1:0] prod;
        logic [CH_W+WEIGHT_W:0]   sum;
        prod = c * p;
        sum  = {1'b0, prod} + (31'd1 << (Q_FRAC - 1));
        return sum[Q_FRAC +: PROD_W];
    endfunction

    // One step of the digit-by-digit integer square root
    function automatic t_sqrt sqrt_step(input t_sqrt s, input logic [SQ_W-1:0] bitv);
        logic [SQ_W:0] trial;
        t_sqrt         r;
        trial = {1'b0, s.root} + {1'b0, bitv};
        if ({1'b0, s.rem} >= trial) begin
            r.rem  = s.rem - trial[SQ_W-1:0];
            r.root = (s.root >> 1) + bitv;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

@@ src/sky_gradient_color.sv @@
// Sky gradient color: twelve-stage pipeline from Q12 elevation to 5-bit RGB.
//
// Maps a signed Q12 elevation to a sky color by blending the horizon, zenith and ground
// colors with weights 31(1-a^7.5), the remainder, and 31(1-b^3), where a=min(1,1-y) and
// b=min(1,1+y). Elevations outside -1.0 .. +1.0 are clamped. One elevation is accepted
// every cycle while o_in_stall is low; the depth is set by the square root
// of a, two result digits per stage over seven stages, running beside the six chained
// multiplies of a^7. Every stage holds a valid bit and only stalls when the stage after
// it is full and stalled, so empty slots fill while the output waits. Color registers
// are read in the product stage and should be written only while the pipeline is empty.
module sky_gradient_color
    import sky_grad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [COLOR_W-1:0]    i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [13:0]    i_elevation,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [4:0]            o_red,
    output logic [4:0]            o_green,
    output logic [4:0]            o_blue
);

    localparam int NSTAGE = 12;
    localparam int SQ_LAST = 7;     // last square root / power stage

    // configuration
    logic [COLOR_W-1:0] r_horizon, r_zenith, r_ground;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon <= HORIZON_RESET;
            r_zenith  <= ZENITH_RESET;
            r_ground  <= GROUND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HORIZON: r_horizon <= i_cfg_data;
                CFG_ZENITH:  r_zenith  <= i_cfg_data;
                CFG_GROUND:  r_ground  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage flow control
    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE:0]   w_en;

    always_comb begin
        w_en[NSTAGE] = !i_out_stall;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_in_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: clamp, form a and b
    logic signed [13:0] w_y;
    logic signed [14:0] w_a_full, w_b_full;
    t_q12               w_a, w_b;

    always_comb begin
        if (i_elevation < -14'sd4096) begin
            w_y = -14'sd4096;
        end else if (i_elevation > 14'sd4096) begin
            w_y = 14'sd4096;
        end else begin
            w_y = i_elevation;
        end
        w_a_full = 15'sd4096 - {w_y[13], w_y};
        w_b_full = 15'sd4096 + {w_y[13], w_y};
        w_a = (w_y > 14'sd0) ? w_a_full[CH_W-1:0] : ONE_Q12;
        w_b = (w_y < 14'sd0) ? w_b_full[CH_W-1:0] : ONE_Q12;
    end

    t_q12  r_a  [0:SQ_LAST];
    t_q12  r_b  [0:SQ_LAST];
    t_q12  r_pw [0:SQ_LAST];
    t_q12  r_bp [0:SQ_LAST];
    t_sqrt r_sq [0:SQ_LAST];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a[0]       <= w_a;
            r_b[0]       <= w_b;
            r_pw[0]      <= w_a;
            r_bp[0]      <= w_b;
            r_sq[0].rem  <= {2'b0, w_a, 12'b0};
            r_sq[0].root <= '0;
        end
    end

    // stages 1..7: two root digits each, a^7 and b^3 multiply chains alongside
    for (genvar j = 1; j <= SQ_LAST; j++) begin : g_sq
        localparam int STEP0 = 2 * (j - 1);
        localparam logic [SQ_W-1:0] BIT0 = 27'd1 << (2 * (SQ_STEPS - 1 - STEP0));
        localparam logic [SQ_W-1:0] BIT1 = 27'd1 << (2 * (SQ_STEPS - 2 - STEP0));

        t_sqrt w_mid, w_out;
        t_q12  w_pw, w_bp;

        always_comb begin
            w_mid = sqrt_step(r_sq[j-1], BIT0);
            w_out = sqrt_step(w_mid, BIT1);
            w_pw  = (j <= 6) ? qmul(r_a[j-1], r_pw[j-1]) : r_pw[j-1];
            if (j == 1) begin
                w_bp = qmul(r_b[j-1], r_b[j-1]);
            end else if (j == 2) begin
                w_bp = qmul(r_b[j-1], r_bp[j-1]);
            end else begin
                w_bp = r_bp[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[j]) begin
                r_a[j]  <= r_a[j-1];
                r_b[j]  <= r_b[j-1];
                r_pw[j] <= w_pw;
                r_bp[j] <= w_bp;
                r_sq[j] <= w_out;
            end
        end
    end

    // stage 8: a^7.5 = sqrt(a) * a^7
    t_q12 r_pw75, r_b3;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_pw75 <= qmul(r_sq[SQ_LAST].root[CH_W-1:0], r_pw[SQ_LAST]);
            r_b3   <= r_bp[SQ_LAST];
        end
    end

    // stage 9: weights; times 31 as shift and subtract
    t_q12              w_x1, w_x3;
    logic [WEIGHT_W:0] w_p1_full, w_p3_full;
    t_weight           w_p1, w_p3;
    t_weight           r_p1, r_p2, r_p3;

    always_comb begin
        w_x1      = ONE_Q12 - r_pw75;
        w_x3      = ONE_Q12 - r_b3;
        w_p1_full = {w_x1, 5'b0} - {5'b0, w_x1};
        w_p3_full = {w_x3, 5'b0} - {5'b0, w_x3};
        w_p1      = w_p1_full[WEIGHT_W-1:0];
        w_p3      = w_p3_full[WEIGHT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_p1 <= w_p1;
            r_p3 <= w_p3;
            // one of p1, p3 is always zero, so this never goes negative
            r_p2 <= WEIGHT_FULL - w_p1 - w_p3;
        end
    end

    // stage 10: nine channel products
    t_prod r_prod [0:2][0:2];   // [channel][color]

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c][0] <= cmul(r_horizon[c*CH_W +: CH_W], r_p1);
                r_prod[c][1] <= cmul(r_zenith[c*CH_W +: CH_W], r_p2);
                r_prod[c][2] <= cmul(r_ground[c*CH_W +: CH_W], r_p3);
            end
        end
    end

    // stage 11: sum, drop fraction, saturate
    logic [PROD_W+1:0] w_sum [0:2];
    logic [4:0]        w_chan [0:2];
    logic [4:0]        r_chan [0:2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = {2'b0, r_prod[c][0]} + {2'b0, r_prod[c][1]} + {2'b0, r_prod[c][2]};
            if (w_sum[c][PROD_W+1:Q_FRAC+5] != '0) begin
                w_chan[c] = 5'd31;
            end else begin
                w_chan[c] = w_sum[c][Q_FRAC +: 5];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            for (int c = 0; c < 3; c++) begin
                r_chan[c] <= w_chan[c];
            end
        end
    end

    assign o_out_valid = r_v[NSTAGE-1];
    assign o_red       = r_chan[0];
    assign o_green     = r_chan[1];
    assign o_blue      = r_chan[2];

`ifndef ASSERT_OFF
    // weights always add to 31.0
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[10] |-> ({1'b0, r_p1} + {1'b0, r_p2} + {1'b0, r_p3}) == {1'b0, WEIGHT_FULL})
        else $error("weights do not sum to 31.0");

    // above the horizon p3 is zero, below it p1 is zero
    a_weight_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[10] |-> (r_p1 == '0 || r_p3 == '0))
        else $error("both outer weights nonzero");

    // square root of a Q12 value within 0 .. 1.0 stays within 0 .. 1.0
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[SQ_LAST] |-> r_sq[SQ_LAST].root <= 27'd4096)
        else $error("square root out of range");

    // a held stage keeps its item
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] && !w_en[6] |=> r_v[5] && $stable(r_pw[5]))
        else $error("stalled stage lost its item");
`endif

endmodule

@@ test/testbench.sv @@
// Testbench for sky_gradient_color: random and corner elevations checked against a predictor.
`timescale 1ns / 1ps

module testbench;
    import sky_grad_pkg::*;

    localparam longint UNITY_Q12    = 4096;
    localparam longint WEIGHT_SCALE = 31;
    localparam int     PHASE_ITEMS  = 250;
    localparam int     NUM_PHASES   = 7;
    localparam int     HOLD_CYCLES  = 200;
    localparam int     SETTLE       = 40;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     MAX_PRINTED  = 40;

    localparam logic [1:0]         CFG_UNUSED = 2'd3;
    localparam logic [COLOR_W-1:0] COLOR_ALL  = {COLOR_W{1'b1}};

    typedef enum logic {STIM_ELEVATION, STIM_WRITE} t_stim_kind;
    typedef enum logic [2:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE, RX_PERIODIC} t_rx_mode;

    typedef struct {
        t_stim_kind         kind;
        logic [1:0]         index;
        logic [COLOR_W-1:0] data;
        logic signed [13:0] elev;
    } t_stim;

    typedef struct packed {
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
    } t_sky_rgb;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_index = CFG_HORIZON;
    logic [COLOR_W-1:0]  cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic signed [13:0]  elevation = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [4:0]          red;
    logic [4:0]          green;
    logic [4:0]          blue;

    // predictor copy of the color registers
    logic [COLOR_W-1:0]  horizon_q = HORIZON_RESET;
    logic [COLOR_W-1:0]  zenith_q  = ZENITH_RESET;
    logic [COLOR_W-1:0]  ground_q  = GROUND_RESET;

    t_stim     work_list[$];
    t_sky_rgb  sky_colors_due[$];

    int        errors         = 0;
    int        elevations_sent = 0;
    int        colors_seen    = 0;
    int        reg_writes     = 0;
    int        cycles         = 0;
    int        burst_left     = 0;
    int        gap_left       = 0;
    int        hold_left      = 0;
    int        next_hold_at   = 400;
    int        mode_left      = 0;
    t_rx_mode  rx_mode        = RX_FREE;

    sky_gradient_color dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_elevation (elevation),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_red       (red),
        .o_green     (green),
        .o_blue      (blue)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic longint q12_mul(input longint x, input longint y);
        return (x * y + 2048) >>> 12;
    endfunction

    function automatic longint floor_sqrt(input longint v);
        longint rest;
        longint root;
        longint probe;
        rest  = v;
        root  = 0;
        probe = longint'(1) << 26;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - root - probe;
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic [4:0] blend_channel(input int lsb, input longint w1,
                                                 input longint w2, input longint w3);
        longint acc;
        acc = q12_mul(longint'(horizon_q[lsb +: 13]), w1)
            + q12_mul(longint'(zenith_q[lsb +: 13]), w2)
            + q12_mul(longint'(ground_q[lsb +: 13]), w3);
        if (acc < 0)
            return 5'd0;
        acc = acc >>> 12;
        if (acc > 31)
            acc = 31;
        return 5'(acc);
    endfunction

    function automatic t_sky_rgb predict_sky(input logic signed [13:0] elev);
        longint   y;
        longint   a;
        longint   b;
        longint   pw;
        longint   p1;
        longint   p2;
        longint   p3;
        t_sky_rgb rgb;
        y = elev;
        if (y < -UNITY_Q12)
            y = -UNITY_Q12;
        if (y > UNITY_Q12)
            y = UNITY_Q12;
        a = UNITY_Q12 - y;
        if (a > UNITY_Q12)
            a = UNITY_Q12;
        // a^7 by six chained multiplies, then times sqrt(a)
        pw = a;
        repeat (6) pw = q12_mul(a, pw);
        pw = q12_mul(floor_sqrt(a << 12), pw);
        p1 = (UNITY_Q12 - pw) * WEIGHT_SCALE;
        b = UNITY_Q12 + y;
        if (b > UNITY_Q12)
            b = UNITY_Q12;
        p3 = (UNITY_Q12 - q12_mul(b, q12_mul(b, b))) * WEIGHT_SCALE;
        p2 = UNITY_Q12 * WEIGHT_SCALE - p1 - p3;
        rgb.red   = blend_channel(0, p1, p2, p3);
        rgb.green = blend_channel(13, p1, p2, p3);
        rgb.blue  = blend_channel(26, p1, p2, p3);
        return rgb;
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic void add_elevation(input int value);
        t_stim s;
        s.kind  = STIM_ELEVATION;
        s.index = CFG_HORIZON;
        s.data  = '0;
        s.elev  = 14'(value);
        work_list.push_back(s);
    endfunction

    function automatic void add_write(input logic [1:0] index, input logic [COLOR_W-1:0] data);
        t_stim s;
        s.kind  = STIM_WRITE;
        s.index = index;
        s.data  = data;
        s.elev  = '0;
        work_list.push_back(s);
    endfunction

    function automatic void set_colors(input logic [COLOR_W-1:0] horizon,
                                       input logic [COLOR_W-1:0] zenith,
                                       input logic [COLOR_W-1:0] ground);
        add_write(CFG_HORIZON, horizon);
        add_write(CFG_ZENITH, zenith);
        add_write(CFG_GROUND, ground);
    endfunction

    function automatic logic [COLOR_W-1:0] random_color();
        logic [COLOR_W-1:0] packed_rgb;
        logic [12:0]        ch;
        packed_rgb = '0;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
                0:       ch = 13'($urandom_range(0, 8191));
                1:       ch = ($urandom_range(0, 1) == 1) ? 13'h1FFF : 13'd0;
                default: ch = 13'($urandom_range(0, 4096));
            endcase
            packed_rgb[k*13 +: 13] = ch;
        end
        return packed_rgb;
    endfunction

    function automatic int random_elevation();
        int near;
        near = int'($urandom_range(0, 8));
        case ($urandom_range(0, 9))
            0, 1:    return int'($urandom_range(0, 16383)) - 8192;   // whole field, clamp path
            2:       return ($urandom_range(0, 1) == 1) ? 4096 - near : -4096 + near;
            3:       return int'($urandom_range(0, 64)) - 32;
            default: return int'($urandom_range(0, 8192)) - 4096;
        endcase
    endfunction

    // ---------------- sender ----------------

    always @(posedge clk) begin : sender
        t_stim head;
        logic  nvalid;
        logic  nwe;
        if (!rst_n) begin
            in_valid <= 1'b0;
            cfg_we   <= 1'b0;
        end else begin
            nvalid = in_valid;
            nwe    = 1'b0;
            if (in_valid && !in_stall) begin
                sky_colors_due.push_back(predict_sky(elevation));
                elevations_sent++;
                nvalid = 1'b0;
                if (burst_left > 0)
                    burst_left--;
            end
            if (!nvalid) begin
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (work_list.size() > 0) begin
                    head = work_list[0];
                    if (head.kind == STIM_ELEVATION) begin
                        nvalid = 1'b1;
                        elevation <= head.elev;
                        void'(work_list.pop_front());
                    end else if (sky_colors_due.size() == 0) begin
                        // pipeline is empty: safe to change the colors
                        nwe = 1'b1;
                        cfg_index <= head.index;
                        cfg_data  <= head.data;
                        case (head.index)
                            CFG_HORIZON: horizon_q = head.data;
                            CFG_ZENITH:  zenith_q  = head.data;
                            CFG_GROUND:  ground_q  = head.data;
                            default:     ;
                        endcase
                        reg_writes++;
                        void'(work_list.pop_front());
                    end
                end
            end
            in_valid <= nvalid;
            cfg_we   <= nwe;
        end
    end

    // ---------------- receiver ----------------

    always @(posedge clk) begin : receiver
        logic nstall;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                nstall = 1'b1;
            end else if (colors_seen >= next_hold_at) begin
                // long hold-off so the pipeline backs up into the input
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + 500;
                nstall       = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 4));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:   nstall = 1'b0;
                    RX_LIGHT:  nstall = ($urandom_range(0, 3) == 0);
                    RX_HEAVY:  nstall = ($urandom_range(0, 3) != 0);
                    RX_TOGGLE: nstall = !out_stall;
                    default:   nstall = ((mode_left % 8) < 3);
                endcase
            end
            out_stall <= nstall;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk) begin : monitor
        t_sky_rgb want;
        if (rst_n && out_valid && !out_stall) begin
            colors_seen++;
            if (sky_colors_due.size() == 0) begin
                report_error($sformatf("color %0d/%0d/%0d with no elevation pending",
                                       red, green, blue));
            end else begin
                want = sky_colors_due.pop_front();
                if (red !== want.red)
                    report_error($sformatf("color %0d: red %0d, predicted %0d",
                                           colors_seen, red, want.red));
                if (green !== want.green)
                    report_error($sformatf("color %0d: green %0d, predicted %0d",
                                           colors_seen, green, want.green));
                if (blue !== want.blue)
                    report_error($sformatf("color %0d: blue %0d, predicted %0d",
                                           colors_seen, blue, want.blue));
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d colors still due",
                     cycles, sky_colors_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- run ----------------

    initial begin
        // corners under the reset colors: full range, clamp edges, bit patterns
        add_elevation(-4096); add_elevation(4096);  add_elevation(0);
        add_elevation(-8192); add_elevation(8191);  add_elevation(-4097);
        add_elevation(4097);  add_elevation(1);     add_elevation(-1);
        add_elevation(2048);  add_elevation(-2048); add_elevation(4095);
        add_elevation(-4095); add_elevation(5461);  add_elevation(-5462);
        add_elevation(100);   add_elevation(-100);  add_elevation(3000);
        add_elevation(-3000); add_elevation(8191);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_colors('0, '0, '0);
                1: set_colors(COLOR_ALL, COLOR_ALL, COLOR_ALL);
                2: set_colors(COLOR_ALL, '0, '0);
                3: begin
                    set_colors(random_color(), random_color(), random_color());
                    add_write(CFG_UNUSED, COLOR_ALL);
                end
                4: begin
                    add_write(CFG_UNUSED, random_color());
                    set_colors(random_color(), random_color(), random_color());
                end
                6: set_colors(HORIZON_RESET, ZENITH_RESET, GROUND_RESET);
                default: set_colors(random_color(), random_color(), random_color());
            endcase
            repeat (PHASE_ITEMS) add_elevation(random_elevation());
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (work_list.size() != 0 || in_valid || sky_colors_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d elevations (corners, clamped values, random) and checked %0d colors",
                 elevations_sent, colors_seen);
        $display("across %0d register writes: reset, zero, full-scale and random colors",
                 reg_writes);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
